// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the link reconnect backoff controller.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define LRB_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
`define LRB_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) else $error(msg);
`else
`define LRB_ASSERT(lbl, clk, rstn, prop, msg)
`define LRB_NEVER(lbl, clk, rstn, cond, msg)
`endif

`endif

// ===== rtl/lrb_pkg.sv =====
// Types and constants of the link reconnect backoff controller.
// No dependencies.
`timescale 1ns / 1ps

package lrb_pkg;

    localparam int REG_W   = 22;
    localparam int RND_W   = 32;
    localparam int FIFTH_W = 20;
    localparam int REM_W   = 21;
    localparam int MS_W    = 10;
    localparam int US_W    = REG_W + MS_W;
    localparam int OUT_W   = 32;
    localparam int CNT_W   = $clog2(RND_W + 1);

    typedef logic [2:0] op_t;
    localparam op_t OP_TICK      = 3'd0;
    localparam op_t OP_LINK_LOST = 3'd1;
    localparam op_t OP_ADDR_ACQ  = 3'd2;
    localparam op_t OP_ADDR_LOST = 3'd3;
    localparam op_t OP_CONN_FAIL = 3'd4;
    localparam op_t OP_ENABLE    = 3'd5;
    localparam op_t OP_DISABLE   = 3'd6;

    typedef logic [1:0] cfg_idx_t;
    localparam cfg_idx_t CFG_RETRY_MIN = 2'd0;
    localparam cfg_idx_t CFG_RETRY_MAX = 2'd1;
    localparam cfg_idx_t CFG_TIMEOUT   = 2'd2;

    localparam logic [REG_W-1:0] RETRY_MIN_RST = 22'd1000;
    localparam logic [REG_W-1:0] RETRY_MAX_RST = 22'd60000;
    localparam logic [REG_W-1:0] TIMEOUT_RST   = 22'd30000;

    localparam logic [MS_W-1:0] US_PER_MS = 10'd1000;

    // ceil(2^24 / 5): exact floor(x / 5) for any 22-bit x
    localparam logic [REG_W-1:0] FIFTH_RECIP = 22'd3355444;
    localparam int FIFTH_SHIFT = 24;

    typedef struct packed {
        logic in_ready;
        logic capture;
        logic eval;
        logic fifth_load;
        logic rem_start;
        logic delay_load;
        logic scale_load;
        logic commit;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic backoff_req;
        logic out_free;
    } sts_t;

endpackage

// ===== rtl/lrb_rem.sv =====
// Bit-serial remainder unit: one dividend bit per cycle.
// Depends on lrb_pkg.
`timescale 1ns / 1ps

module lrb_rem (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [lrb_pkg::RND_W-1:0]   dividend,
    input  logic [lrb_pkg::REM_W-1:0]   divisor,
    output logic                        done,
    output logic [lrb_pkg::REM_W-1:0]   remainder
);

    logic [lrb_pkg::RND_W-1:0] dvd_reg, dvd_next;
    logic [lrb_pkg::REM_W-1:0] dvs_reg, dvs_next;
    logic [lrb_pkg::REM_W-1:0] rem_reg, rem_next;
    logic [lrb_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic                      done_reg, done_next;
    logic [lrb_pkg::REM_W:0]   partial;
    logic [lrb_pkg::REM_W:0]   diff;

    assign partial = {rem_reg, dvd_reg[lrb_pkg::RND_W-1]};
    assign diff    = partial - {1'b0, dvs_reg};

    always_comb begin
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start) begin
            dvd_next = dividend;
            dvs_next = divisor;
            rem_next = '0;
            cnt_next = lrb_pkg::CNT_W'(lrb_pkg::RND_W);
        end else if (cnt_reg != '0) begin
            dvd_next  = {dvd_reg[lrb_pkg::RND_W-2:0], 1'b0};
            rem_next  = (partial >= {1'b0, dvs_reg}) ? diff[lrb_pkg::REM_W-1:0]
                                                     : partial[lrb_pkg::REM_W-1:0];
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == lrb_pkg::CNT_W'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

// ===== rtl/lrb_ctrl.sv =====
// Sequencer of the link reconnect backoff controller.
// Depends on lrb_pkg.
`timescale 1ns / 1ps

module lrb_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    input  lrb_pkg::sts_t sts,
    input  logic          rem_done,
    output lrb_pkg::cmd_t cmd
);

    typedef enum logic [8:0] {
        S_IDLE    = 9'b000000001,
        S_EVAL    = 9'b000000010,
        S_FIFTH   = 9'b000000100,
        S_DIVGO   = 9'b000001000,
        S_DIVWAIT = 9'b000010000,
        S_DELAY   = 9'b000100000,
        S_SCALE   = 9'b001000000,
        S_COMMIT  = 9'b010000000,
        S_FINISH  = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                cmd.in_ready = 1'b1;
                cmd.capture  = s_tvalid;
                if (s_tvalid) state_next = S_EVAL;
            end
            S_EVAL: begin
                cmd.eval   = 1'b1;
                state_next = sts.backoff_req ? S_FIFTH : S_FINISH;
            end
            S_FIFTH: begin
                cmd.fifth_load = 1'b1;
                state_next     = S_DIVGO;
            end
            S_DIVGO: begin
                cmd.rem_start = 1'b1;
                state_next    = S_DIVWAIT;
            end
            S_DIVWAIT: begin
                if (rem_done) state_next = S_DELAY;
            end
            S_DELAY: begin
                cmd.delay_load = 1'b1;
                state_next     = S_SCALE;
            end
            S_SCALE: begin
                cmd.scale_load = 1'b1;
                state_next     = S_COMMIT;
            end
            S_COMMIT: begin
                cmd.commit = 1'b1;
                state_next = S_FINISH;
            end
            S_FINISH: begin
                cmd.out_load = sts.out_free;
                if (sts.out_free) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/lrb_dp.sv =====
// Datapath: configuration, link state, backoff arithmetic and result register.
// Depends on lrb_pkg; driven by lrb_ctrl, uses lrb_rem for the jitter remainder.
`timescale 1ns / 1ps

module lrb_dp #(
    parameter int TIME_BITS = 48
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  lrb_pkg::cmd_t                   cmd,
    output lrb_pkg::sts_t                   sts,
    input  logic [((TIME_BITS+33+7)/8)*8-1:0] s_tdata,
    input  logic [2:0]                      s_tuser,
    input  logic                            cfg_valid,
    input  lrb_pkg::cfg_idx_t               cfg_index,
    input  logic [lrb_pkg::REG_W-1:0]       cfg_data,
    output logic [lrb_pkg::RND_W-1:0]       rem_dividend,
    output logic [lrb_pkg::REM_W-1:0]       rem_divisor,
    input  logic [lrb_pkg::REM_W-1:0]       rem_value,
    input  logic                            m_tready,
    output logic                            m_tvalid,
    output logic [lrb_pkg::OUT_W-1:0]       m_tdata
);

    localparam int REG_W = lrb_pkg::REG_W;

    logic [REG_W-1:0] min_reg, max_reg, tmo_reg;

    logic             en_reg, en_next;
    logic             att_reg, att_next;
    logic             conn_reg, conn_next;
    logic [REG_W-1:0] ivl_reg, ivl_next;
    logic [TIME_BITS-1:0] dl_reg, dl_next;

    lrb_pkg::op_t               op_reg;
    logic [TIME_BITS-1:0]       now_reg;
    logic [lrb_pkg::RND_W-1:0]  rnd_reg;
    logic                       match_reg;
    logic [lrb_pkg::US_W-1:0]   tmo_us_reg;

    logic                       before_reg;
    logic                       start_reg, start_next;
    logic                       drop_reg, drop_next;
    logic                       sched_reg;
    logic [REG_W-1:0]           sdly_reg;

    logic [lrb_pkg::FIFTH_W-1:0] fifth_reg;
    logic [REG_W-1:0]            delay_reg;
    logic [lrb_pkg::US_W-1:0]    dly_us_reg;
    logic [2*REG_W-1:0]          fifth_prod;

    logic                       backoff;
    logic                       due;

    logic                       mv_reg;
    logic [lrb_pkg::OUT_W-1:0]  md_reg;

    assign due        = now_reg >= dl_reg;
    assign fifth_prod = ivl_reg * lrb_pkg::FIFTH_RECIP;

    always_comb begin
        en_next    = en_reg;
        att_next   = att_reg;
        conn_next  = conn_reg;
        ivl_next   = ivl_reg;
        dl_next    = dl_reg;
        start_next = start_reg;
        drop_next  = drop_reg;
        backoff    = 1'b0;
        unique case (op_reg)
            lrb_pkg::OP_TICK: begin
                if (en_reg && !conn_reg && due) begin
                    if (att_reg) begin
                        drop_next = 1'b1;
                        backoff   = 1'b1;
                    end else begin
                        att_next   = 1'b1;
                        dl_next    = now_reg + TIME_BITS'(tmo_us_reg);
                        start_next = 1'b1;
                    end
                end
            end
            lrb_pkg::OP_LINK_LOST: begin
                conn_next = 1'b0;
                backoff   = en_reg && (conn_reg || att_reg);
            end
            lrb_pkg::OP_ADDR_ACQ: begin
                if (en_reg && match_reg) begin
                    att_next  = 1'b0;
                    ivl_next  = min_reg;
                    conn_next = 1'b1;
                end
            end
            lrb_pkg::OP_ADDR_LOST: begin
                if (en_reg) begin
                    conn_next = 1'b0;
                    att_next  = 1'b1;
                    dl_next   = now_reg;
                end
            end
            lrb_pkg::OP_CONN_FAIL: begin
                backoff = en_reg && att_reg && !conn_reg;
            end
            lrb_pkg::OP_ENABLE: begin
                att_next  = 1'b0;
                conn_next = 1'b0;
                drop_next = 1'b1;
                ivl_next  = min_reg;
                dl_next   = '0;
                en_next   = 1'b1;
            end
            lrb_pkg::OP_DISABLE: begin
                en_next   = 1'b0;
                att_next  = 1'b0;
                conn_next = 1'b0;
                drop_next = 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign sts.backoff_req = backoff;
    assign sts.out_free    = !mv_reg || m_tready;

    assign rem_dividend = rnd_reg;
    assign rem_divisor  = {1'b0, fifth_reg} + 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_reg  <= lrb_pkg::RETRY_MIN_RST;
            max_reg  <= lrb_pkg::RETRY_MAX_RST;
            tmo_reg  <= lrb_pkg::TIMEOUT_RST;
            en_reg   <= 1'b0;
            att_reg  <= 1'b0;
            conn_reg <= 1'b0;
            ivl_reg  <= lrb_pkg::RETRY_MIN_RST;
            dl_reg   <= '0;
            mv_reg   <= 1'b0;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    lrb_pkg::CFG_RETRY_MIN: min_reg <= cfg_data;
                    lrb_pkg::CFG_RETRY_MAX: max_reg <= cfg_data;
                    lrb_pkg::CFG_TIMEOUT:   tmo_reg <= cfg_data;
                    default: begin
                    end
                endcase
            end
            if (cmd.eval) begin
                en_reg   <= en_next;
                att_reg  <= att_next;
                conn_reg <= conn_next;
                ivl_reg  <= ivl_next;
                dl_reg   <= dl_next;
            end
            if (cmd.commit) begin
                att_reg <= 1'b0;
                dl_reg  <= now_reg + TIME_BITS'(dly_us_reg);
                ivl_reg <= (ivl_reg >= (max_reg >> 1)) ? max_reg
                                                       : {ivl_reg[REG_W-2:0], 1'b0};
            end
            if (cmd.out_load) begin
                mv_reg <= 1'b1;
            end else if (m_tready) begin
                mv_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg     <= s_tuser;
            now_reg    <= s_tdata[TIME_BITS-1:0];
            rnd_reg    <= s_tdata[TIME_BITS +: lrb_pkg::RND_W];
            match_reg  <= s_tdata[TIME_BITS+lrb_pkg::RND_W];
            tmo_us_reg <= tmo_reg * lrb_pkg::US_PER_MS;
            before_reg <= conn_reg;
            start_reg  <= 1'b0;
            drop_reg   <= 1'b0;
            sched_reg  <= 1'b0;
            sdly_reg   <= '0;
        end
        if (cmd.eval) begin
            start_reg <= start_next;
            drop_reg  <= drop_next;
        end
        if (cmd.fifth_load) begin
            fifth_reg <= fifth_prod[lrb_pkg::FIFTH_SHIFT +: lrb_pkg::FIFTH_W];
        end
        if (cmd.delay_load) begin
            delay_reg <= ivl_reg - REG_W'(fifth_reg) + REG_W'(rem_value);
        end
        if (cmd.scale_load) begin
            dly_us_reg <= delay_reg * lrb_pkg::US_PER_MS;
        end
        if (cmd.commit) begin
            sched_reg <= 1'b1;
            sdly_reg  <= delay_reg;
        end
        if (cmd.out_load) begin
            md_reg <= {5'b0, sdly_reg, sched_reg, drop_reg, start_reg,
                       conn_reg != before_reg, conn_reg};
        end
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = md_reg;

endmodule

// ===== rtl/link_reconnect_backoff_controller_unit.sv =====
// Top level of the link reconnect backoff controller.
// Depends on lrb_pkg, assert_macros.svh, lrb_ctrl, lrb_dp and lrb_rem.
//
// Usage: link events enter on the s_ stream (operation in s_tuser, time,
// random word and address-matches flag in s_tdata); one result per event
// leaves on the m_ stream. Registers (retry min, retry max, connect
// timeout, all in ms) are written through cfg_valid/cfg_index/cfg_data
// by the user only while no event is in flight; the block does not
// enforce this. cfg_ready is always high. An event that schedules no
// retry goes from evaluation straight to the finish state; one that
// schedules a retry also passes the fifth, remainder, delay, scale and
// commit states, the bit-serial jitter remainder taking 32 steps, one
// dividend bit a cycle. One event is worked on at a time; s_tready rises
// again once the result has moved into the output register.
// A finished result waits in the output register while the next event
// is accepted; a stall on m_tready holds only the event after that.
// Reset (aresetn low, synchronous) restores register defaults, clears
// the link state and empties the output register.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module link_reconnect_backoff_controller_unit #(
    parameter int TIME_BITS = 48
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // now_us [TIME_BITS-1:0], random_value [+32], ssid_matches [+1], zero pad
    input  logic [((TIME_BITS+33+7)/8)*8-1:0] s_tdata,
    // operation [2:0]
    input  logic [2:0]                        s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // link_up, link_changed, start_connect, drop_link, retry_scheduled,
    // retry_delay_ms [26:5], zero pad
    output logic [lrb_pkg::OUT_W-1:0]         m_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [1:0]                        cfg_index,
    input  logic [lrb_pkg::REG_W-1:0]         cfg_data
);

    lrb_pkg::cmd_t              cmd;
    lrb_pkg::sts_t              sts;
    logic                       rem_done;
    logic [lrb_pkg::RND_W-1:0]  rem_dividend;
    logic [lrb_pkg::REM_W-1:0]  rem_divisor;
    logic [lrb_pkg::REM_W-1:0]  rem_value;

    assign cfg_ready = 1'b1;
    assign s_tready  = cmd.in_ready;

    lrb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .sts      (sts),
        .rem_done (rem_done),
        .cmd      (cmd)
    );

    lrb_rem u_rem (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.rem_start),
        .dividend  (rem_dividend),
        .divisor   (rem_divisor),
        .done      (rem_done),
        .remainder (rem_value)
    );

    lrb_dp #(
        .TIME_BITS (TIME_BITS)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .sts          (sts),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .rem_dividend (rem_dividend),
        .rem_divisor  (rem_divisor),
        .rem_value    (rem_value),
        .m_tready     (m_tready),
        .m_tvalid     (m_tvalid),
        .m_tdata      (m_tdata)
    );

    `LRB_ASSERT(a_load_when_free, aclk, aresetn, cmd.out_load |-> sts.out_free, "result overwritten")
    `LRB_ASSERT(a_one_at_a_time, aclk, aresetn, (s_tvalid && s_tready) |=> !s_tready, "second item taken")
    `LRB_ASSERT(a_start_then_busy, aclk, aresetn, cmd.rem_start |=> !rem_done, "remainder done too early")
    `LRB_ASSERT(a_cmd_onehot, aclk, aresetn, $onehot0({cmd.eval, cmd.fifth_load, cmd.rem_start, cmd.delay_load, cmd.scale_load, cmd.commit, cmd.out_load}), "overlapping commands")

endmodule
